// File: rtl/frfm_pkg.sv
// ----------------------------------------------------------------------------
// frfm_pkg: shared types and codes
// request codes, entry kinds and config register indexes for the rule matcher
// ----------------------------------------------------------------------------
package frfm_pkg;

  typedef enum logic [1:0] {
    REQ_CLASSIFY = 2'd0,
    REQ_WR_ZONE  = 2'd1,
    REQ_WR_NET   = 2'd2,
    REQ_WR_SVC   = 2'd3
  } req_t;

  localparam logic [2:0] NK_HOST     = 3'd0;
  localparam logic [2:0] NK_NET      = 3'd1;
  localparam logic [2:0] NK_GEO      = 3'd2;
  localparam logic [2:0] NK_INV_HOST = 3'd3;
  localparam logic [2:0] NK_INV_NET  = 3'd4;
  localparam logic [2:0] NK_INV_GEO  = 3'd5;

  localparam logic [1:0] SK_SOLO  = 2'd0;
  localparam logic [1:0] SK_RANGE = 2'd1;
  localparam logic [1:0] SK_ICMP  = 2'd2;
  localparam logic [1:0] SK_NONE  = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;

  localparam logic [2:0] REG_ZONE_COUNT = 3'd0;
  localparam logic [2:0] REG_NET_COUNT  = 3'd1;
  localparam logic [2:0] REG_SVC_COUNT  = 3'd2;
  localparam logic [2:0] REG_WILD_ZONE  = 3'd3;
  localparam logic [2:0] REG_ANY_PROTO  = 3'd4;

  // packet key broadcast to every cell
  typedef struct packed {
    logic [7:0]  zone;
    logic [31:0] ip;
    logic [7:0]  country;
    logic [7:0]  protocol;
    logic [15:0] service;
  } pkt_key_t;

  // entry write broadcast
  typedef struct packed {
    logic [1:0]  req;
    logic [4:0]  slot;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [31:0] mask_end;
    logic [7:0]  protocol;
  } wr_item_t;

endpackage

// File: rtl/frfm_zone_cell.sv
// ----------------------------------------------------------------------------
// frfm_zone_cell: one zone table entry
// holds one zone id and ors its hit into the running hit from its neighbor
// ----------------------------------------------------------------------------
module frfm_zone_cell import frfm_pkg::*; (
  input  logic       clk,
  input  logic       wr_en,
  input  logic [7:0] wr_zone,
  input  logic       active,
  input  logic [7:0] key_zone,
  input  logic       hit_in,
  output logic       hit_out,
  output logic [7:0] zone_out
);
  logic [7:0] zone_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      zone_r <= wr_zone;
    end
  end

  assign zone_out = zone_r;
  assign hit_out  = hit_in | (active & (zone_r == key_zone));
endmodule

// File: rtl/frfm_net_cell.sv
// ----------------------------------------------------------------------------
// frfm_net_cell: one network object entry
// host, masked network or geo compare, each with an inverse form
// ----------------------------------------------------------------------------
module frfm_net_cell import frfm_pkg::*; (
  input  logic        clk,
  input  logic        wr_en,
  input  wr_item_t    wr,
  input  logic        active,
  input  pkt_key_t    key,
  input  logic        hit_in,
  output logic        hit_out
);
  logic [2:0]  kind_r;
  logic [31:0] id_r;
  logic [31:0] mask_r;
  logic        eq_host, eq_net, eq_geo, hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      kind_r <= wr.kind;
      id_r   <= wr.value;
      mask_r <= wr.mask_end;
    end
  end

  always_comb begin
    eq_host = (key.ip == id_r);
    eq_net  = ((key.ip & mask_r) == id_r);
    eq_geo  = (id_r == {24'd0, key.country});
    case (kind_r)
      NK_HOST:     hit = eq_host;
      NK_NET:      hit = eq_net;
      NK_GEO:      hit = eq_geo;
      NK_INV_HOST: hit = !eq_host;
      NK_INV_NET:  hit = !eq_net;
      NK_INV_GEO:  hit = !eq_geo;
      default:     hit = 1'b0;
    endcase
  end

  assign hit_out = hit_in | (active & hit);
endmodule

// File: rtl/frfm_svc_cell.sv
// ----------------------------------------------------------------------------
// frfm_svc_cell: one service entry
// solo port, port range or icmp type/code compare
// ----------------------------------------------------------------------------
module frfm_svc_cell import frfm_pkg::*; (
  input  logic        clk,
  input  logic        wr_en,
  input  wr_item_t    wr,
  input  logic        active,
  input  logic [7:0]  any_proto,
  input  pkt_key_t    key,
  input  logic        hit_in,
  output logic        hit_out
);
  logic [1:0]  kind_r;
  logic [7:0]  proto_r;
  logic [15:0] low_r;
  logic [15:0] high_r;
  logic        fits, hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      kind_r  <= (wr.kind > 3'd2) ? SK_NONE : wr.kind[1:0];
      proto_r <= wr.protocol;
      low_r   <= wr.value[15:0];
      high_r  <= wr.mask_end[15:0];
    end
  end

  always_comb begin
    fits = (proto_r == key.protocol) || (proto_r == any_proto);
    case (kind_r)
      SK_SOLO:  hit = fits && (key.service == low_r);
      SK_RANGE: hit = fits && (key.service >= low_r) && (key.service <= high_r);
      SK_ICMP:  hit = (key.protocol == PROTO_ICMP) && (key.service == low_r);
      default:  hit = 1'b0;
    endcase
  end

  assign hit_out = hit_in | (active & hit);
endmodule

// File: rtl/firewall_rule_field_matcher.sv
// ----------------------------------------------------------------------------
// firewall_rule_field_matcher: rule side field matcher
// zone, network and service tables as rows of compare cells with an or chain
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | in_tuser (request), in_tdata (entry + key)
//  out_    | out | out_tvalid / out_tready| out_tdata (three hit flags)
//  cfg_    | in  | apb write/read         | five count/code registers
//
// one item per cycle: every entry sits in its own cell and all cells compare
// the same key at once; hits ripple down each row's or chain
// the result is registered and shows the cycle after its input transfer
// the result register is refilled while the old result is taken, so the
// input stalls only when out_tready is low with a result waiting
// rst_n (synchronous) clears the config registers and the output valid; table
// contents and the result hit bits stay undefined until written
module firewall_rule_field_matcher import frfm_pkg::*; #(
  parameter int ZONE_SLOTS = 16,
  parameter int NET_SLOTS  = 16,
  parameter int SVC_SLOTS  = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[1:0]
  input  logic [1:0]   in_tuser,
  // slot[4:0] entry_kind[7:5] entry_value[39:8] entry_mask_or_end[71:40]
  // entry_protocol[79:72] zone[87:80] pkt_ip[119:88] pkt_country[127:120]
  // protocol[135:128] pkt_service[151:136]
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // zone_hit[0] net_hit[1] svc_hit[2], zero pad
  output logic [7:0]   out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic [4:0] zone_count_r;
  logic [4:0] net_count_r;
  logic [5:0] svc_count_r;
  logic [7:0] wild_zone_r;
  logic [7:0] any_proto_r;
  logic [2:0] cfg_idx;
  logic       cfg_we;

  wr_item_t wr;
  pkt_key_t key;
  logic     in_fire, classify;

  logic [ZONE_SLOTS:0] zone_chain;
  logic [NET_SLOTS:0]  net_chain;
  logic [SVC_SLOTS:0]  svc_chain;
  logic [7:0]          zone0;
  logic                zone_hit, net_hit, svc_hit;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] hits_r, hits_nxt;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r <= '0;
      net_count_r  <= '0;
      svc_count_r  <= '0;
      wild_zone_r  <= '0;
      any_proto_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ZONE_COUNT: zone_count_r <= cfg_pwdata[4:0];
        REG_NET_COUNT:  net_count_r  <= cfg_pwdata[4:0];
        REG_SVC_COUNT:  svc_count_r  <= cfg_pwdata[5:0];
        REG_WILD_ZONE:  wild_zone_r  <= cfg_pwdata[7:0];
        REG_ANY_PROTO:  any_proto_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_ZONE_COUNT: cfg_prdata = {27'd0, zone_count_r};
      REG_NET_COUNT:  cfg_prdata = {27'd0, net_count_r};
      REG_SVC_COUNT:  cfg_prdata = {26'd0, svc_count_r};
      REG_WILD_ZONE:  cfg_prdata = {24'd0, wild_zone_r};
      REG_ANY_PROTO:  cfg_prdata = {24'd0, any_proto_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // unpack the item
  assign wr.req      = in_tuser;
  assign wr.slot     = in_tdata[4:0];
  assign wr.kind     = in_tdata[7:5];
  assign wr.value    = in_tdata[39:8];
  assign wr.mask_end = in_tdata[71:40];
  assign wr.protocol = in_tdata[79:72];
  assign key.zone     = in_tdata[87:80];
  assign key.ip       = in_tdata[119:88];
  assign key.country  = in_tdata[127:120];
  assign key.protocol = in_tdata[135:128];
  assign key.service  = in_tdata[151:136];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign classify  = (wr.req == REQ_CLASSIFY);

  assign zone_chain[0] = 1'b0;
  assign net_chain[0]  = 1'b0;
  assign svc_chain[0]  = 1'b0;

  // zone row; cell 0 also feeds the wildcard check
  for (genvar i = 0; i < ZONE_SLOTS; i++) begin : g_zone
    logic [7:0] zout;
    frfm_zone_cell u_cell (
      .clk      (clk),
      .wr_en    (in_fire && wr.req == REQ_WR_ZONE && {27'd0, wr.slot} == i),
      .wr_zone  (wr.value[7:0]),
      .active   ({27'd0, zone_count_r} > i),
      .key_zone (key.zone),
      .hit_in   (zone_chain[i]),
      .hit_out  (zone_chain[i+1]),
      .zone_out (zout)
    );
    if (i == 0) begin : g_z0
      assign zone0 = zout;
    end
  end

  // network row
  for (genvar i = 0; i < NET_SLOTS; i++) begin : g_net
    frfm_net_cell u_cell (
      .clk     (clk),
      .wr_en   (in_fire && wr.req == REQ_WR_NET && {27'd0, wr.slot} == i),
      .wr      (wr),
      .active  ({27'd0, net_count_r} > i),
      .key     (key),
      .hit_in  (net_chain[i]),
      .hit_out (net_chain[i+1])
    );
  end

  // service row
  for (genvar i = 0; i < SVC_SLOTS; i++) begin : g_svc
    frfm_svc_cell u_cell (
      .clk       (clk),
      .wr_en     (in_fire && wr.req == REQ_WR_SVC && {27'd0, wr.slot} == i),
      .wr        (wr),
      .active    ({26'd0, svc_count_r} > i),
      .any_proto (any_proto_r),
      .key       (key),
      .hit_in    (svc_chain[i]),
      .hit_out   (svc_chain[i+1])
    );
  end

  assign zone_hit = zone_chain[ZONE_SLOTS] |
                    ((zone_count_r != 5'd0) && (zone0 == wild_zone_r));
  assign net_hit  = net_chain[NET_SLOTS];
  assign svc_hit  = svc_chain[SVC_SLOTS];

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    hits_nxt      = hits_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      hits_nxt      = classify ? {svc_hit, net_hit, zone_hit} : 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hits_r <= hits_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, hits_r};
endmodule

// File: rtl/frfm_checker.sv
// ----------------------------------------------------------------------------
// frfm_checker: port level checks
// watches the stream ports of the matcher over time
// ----------------------------------------------------------------------------
module frfm_checker import frfm_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [7:0]   out_tdata
);
  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every accepted item shows a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after transfer");

  // a write item never reports a hit
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != REQ_CLASSIFY |=> out_tdata == 8'd0)
    else $error("write item reported a hit");

  // input is open whenever the result side is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with free output");
endmodule

bind firewall_rule_field_matcher frfm_checker u_frfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
